// ----- hdl/lkvc_pkg.sv -----
// lkvc_pkg: shared constants and types for the lru key/value cache
// no dependencies; used by lru_key_value_cache
`default_nettype none

package lkvc_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int CFG_W       = 5;
    localparam int ENTRY_W     = KEY_W + VAL_W;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

    localparam logic MODE_LOOKUP = 1'b0;
    localparam logic MODE_STORE  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_RESULT
    } state_t;

endpackage

`default_nettype wire

// ----- hdl/lkvc_ram.sv -----
// lkvc_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module lkvc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                                         clk,
    input  wire logic                                         we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                             wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- hdl/lru_key_value_cache.sv -----
// lru_key_value_cache: fully associative key/value store with lru replacement
// depends on lkvc_pkg and lkvc_ram
//
// channel   dir  signals                          contents (lowest bit up)
// s_*       in   s_tvalid s_tready s_tdata s_tuser request: key, value / mode
// m_*       out  m_tvalid m_tready m_tdata m_tuser result: read_value / hit
// cfg_*     in   cfg_we cfg_wdata                 entries_in_use
//
// a request is accepted while idle, then a pipelined key scan over the ram read
// port compares the valid entries in recency order until a match, then the
// recency move and, for a store, the ram write; a lookup then loads the result register.
// reset clears the count and sets the recency order to identity; ram content
// is left as is. s_tready is high only while idle; a held result stalls the
// next lookup only at the point it needs the result register.
`default_nettype none

module lru_key_value_cache (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [63:0]                   s_tdata,   // lookup_key, store_value
    input  wire logic [0:0]                    s_tuser,   // mode
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [31:0]                   m_tdata,   // read_value
    output logic      [0:0]                    m_tuser,   // hit
    input  wire logic                          cfg_we,
    input  wire logic [lkvc_pkg::CFG_W-1:0]    cfg_wdata
);

    localparam int IDX_W = lkvc_pkg::IDX_W;
    localparam int CNT_W = lkvc_pkg::CNT_W;
    localparam int KEY_W = lkvc_pkg::KEY_W;
    localparam int VAL_W = lkvc_pkg::VAL_W;
    localparam int MAXN  = lkvc_pkg::MAX_ENTRIES;

    lkvc_pkg::state_t state_reg, state_next;

    logic [lkvc_pkg::CFG_W-1:0] cfg_reg;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [CNT_W-1:0]           pos_reg, pos_next;
    logic                       pend_reg, pend_next;
    logic [CNT_W-1:0]           cmp_pos_reg;
    logic [CNT_W-1:0]           mv_pos_reg, mv_pos_next;
    logic                       do_move_reg, do_move_next;
    logic                       mode_reg, mode_next;
    logic [KEY_W-1:0]           key_reg, key_next;
    logic [VAL_W-1:0]           sval_reg, sval_next;
    logic                       hit_reg, hit_next;
    logic [VAL_W-1:0]           rval_reg, rval_next;
    logic                       m_valid_reg, m_valid_next;
    logic                       out_hit_reg, out_hit_next;
    logic [VAL_W-1:0]           out_val_reg, out_val_next;

    logic [IDX_W-1:0] order_reg  [MAXN];
    logic [IDX_W-1:0] order_next [MAXN];

    logic [IDX_W-1:0]              ord_idx;
    logic [IDX_W-1:0]              ord_slot;
    logic                          issue;
    logic                          match;
    logic [CNT_W-1:0]              cap;
    logic [CNT_W-1:0]              ins_pos;
    logic                          ram_we;
    logic [lkvc_pkg::ENTRY_W-1:0]  ram_rdata;

    // shared recency read port: scan position or move position
    assign ord_idx  = (state_reg == lkvc_pkg::ST_SCAN) ? pos_reg[IDX_W-1:0]
                                                       : mv_pos_reg[IDX_W-1:0];
    assign ord_slot = order_reg[ord_idx];

    assign issue = (pos_reg < count_reg);
    assign match = pend_reg && (ram_rdata[KEY_W-1:0] == key_reg);

    always_comb
    begin
        if (cfg_reg == '0)
        begin
            cap = CNT_W'(1);
        end
        else if (32'(cfg_reg) > MAXN)
        begin
            cap = CNT_W'(MAXN);
        end
        else
        begin
            cap = CNT_W'(cfg_reg);
        end
        ins_pos = (count_reg >= cap) ? (cap - CNT_W'(1)) : count_reg;
    end

    lkvc_ram #(
        .WIDTH (lkvc_pkg::ENTRY_W),
        .DEPTH (MAXN)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ord_slot),
        .wdata ({sval_reg, key_reg}),
        .raddr (ord_slot),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        pend_next    = pend_reg;
        mv_pos_next  = mv_pos_reg;
        do_move_next = do_move_reg;
        mode_next    = mode_reg;
        key_next     = key_reg;
        sval_next    = sval_reg;
        hit_next     = hit_reg;
        rval_next    = rval_reg;
        out_hit_next = out_hit_reg;
        out_val_next = out_val_reg;
        order_next   = order_reg;
        ram_we       = 1'b0;
        m_valid_next = m_valid_reg && !m_tready;

        case (state_reg)
            lkvc_pkg::ST_IDLE:
            begin
                pend_next = 1'b0;
                if (s_tvalid)
                begin
                    mode_next  = s_tuser[0];
                    key_next   = s_tdata[KEY_W-1:0];
                    sval_next  = s_tdata[KEY_W+VAL_W-1:KEY_W];
                    pos_next   = '0;
                    state_next = lkvc_pkg::ST_SCAN;
                end
            end
            lkvc_pkg::ST_SCAN:
            begin
                pend_next = issue;
                if (issue)
                begin
                    pos_next = pos_reg + CNT_W'(1);
                end
                if (match)
                begin
                    hit_next     = 1'b1;
                    rval_next    = ram_rdata[KEY_W+VAL_W-1:KEY_W];
                    mv_pos_next  = cmp_pos_reg;
                    do_move_next = 1'b1;
                    state_next   = lkvc_pkg::ST_UPDATE;
                end
                else if (!issue && !pend_reg)
                begin
                    hit_next     = 1'b0;
                    rval_next    = '0;
                    mv_pos_next  = ins_pos;
                    do_move_next = (mode_reg == lkvc_pkg::MODE_STORE);
                    state_next   = lkvc_pkg::ST_UPDATE;
                end
            end
            lkvc_pkg::ST_UPDATE:
            begin
                if (do_move_reg)
                begin
                    // move to front
                    order_next[0] = ord_slot;
                    for (int i = 1; i < MAXN; i++)
                    begin
                        if (CNT_W'(i) <= mv_pos_reg)
                        begin
                            order_next[i] = order_reg[i-1];
                        end
                    end
                end
                if (mode_reg == lkvc_pkg::MODE_STORE)
                begin
                    ram_we = 1'b1;
                    if (!hit_reg)
                    begin
                        count_next = mv_pos_reg + CNT_W'(1);
                    end
                    state_next = lkvc_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = lkvc_pkg::ST_RESULT;
                end
            end
            lkvc_pkg::ST_RESULT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    out_hit_next = hit_reg;
                    out_val_next = rval_reg;
                    state_next   = lkvc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lkvc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= lkvc_pkg::ST_IDLE;
            cfg_reg     <= lkvc_pkg::CFG_RESET;
            count_reg   <= '0;
            pos_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < MAXN; i++)
            begin
                order_reg[i] <= IDX_W'(i);
            end
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pos_reg     <= pos_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
            order_reg   <= order_next;
            if (cfg_we)
            begin
                cfg_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_pos_reg <= pos_reg;
        mv_pos_reg  <= mv_pos_next;
        do_move_reg <= do_move_next;
        mode_reg    <= mode_next;
        key_reg     <= key_next;
        sval_reg    <= sval_next;
        hit_reg     <= hit_next;
        rval_reg    <= rval_next;
        out_hit_reg <= out_hit_next;
        out_val_reg <= out_val_next;
    end

    assign s_tready   = (state_reg == lkvc_pkg::ST_IDLE);
    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = out_val_reg;
    assign m_tuser[0] = out_hit_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAXN))
        else $error("entry count above capacity");

    a_result_lookup_only: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lkvc_pkg::ST_RESULT) |-> (mode_reg == lkvc_pkg::MODE_LOOKUP))
        else $error("result pending for a store");

    a_count_idle_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lkvc_pkg::ST_IDLE && !s_tvalid) |=> $stable(count_reg))
        else $error("entry count changed while idle");

    a_compare_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lkvc_pkg::ST_SCAN && pend_reg) |-> (cmp_pos_reg < count_reg))
        else $error("compare on an invalid recency position");

endmodule

`default_nettype wire
